FILE: rtl/core/tmf_pkg.sv
// Shared constants for the trimmed-mean sample filter.
package tmf_pkg;

  // Width of the filtered result field; results are truncated to this width.
  localparam int unsigned OUT_BITS = 12;

  // Narrowest width that holds the numbers 0 .. n-1, at least one bit.
  function automatic int unsigned idx_bits(input int unsigned n);
    int unsigned b;
    b = 1;
    while ((1 << b) < n) b = b + 1;
    return b;
  endfunction

endpackage

FILE: rtl/core/tmf_channels.sv
// Valid/ready channel interfaces for filter samples and filter results.
interface tmf_sample_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface tmf_result_if
  import tmf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

FILE: rtl/core/trimmed_mean_sample_filter_top.sv
// Top level of the trimmed-mean sample filter: window min/max tracking and quotient sum.
// The filter takes one converter sample per clock cycle in sustained operation and groups
// the samples into windows of WINDOW consecutive samples. Each sample is divided by
// WINDOW-2 with truncation, and the quotients are summed; when the last sample of a
// window arrives, the quotients of one smallest and one largest sample are subtracted and
// the result is offered on the output channel as one transaction. All other samples produce
// no output transaction. A sample passes an input register, then a stage that forms its
// quotient with one constant-reciprocal multiplier, and is folded into the running state
// by the accumulate stage; when a window's last sample fires there, its result is loaded
// into the output register. The rate of one sample per cycle is set by that single
// multiplier and the accumulate stage, both of which are fully pipelined. The result sits
// in its own output register, so samples keep flowing while a result waits; the input
// stalls only when a window's last sample reaches the accumulate stage while the previous
// result has not yet been taken. Results are truncated to 12 bits. Reset is synchronous
// and active low and needs no clearing pass; the input is not ready while reset is held.
module trimmed_mean_sample_filter_top
  import tmf_pkg::*;
#(
  parameter int WINDOW      = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  tmf_sample_if.sink   in_ch,
  tmf_result_if.source out_ch
);

  // Divisor and exact reciprocal for floor(s / KEPT) over all SAMPLE_BITS-bit values.
  localparam int unsigned KEPT     = WINDOW - 2;
  localparam int unsigned KEPT_LOG = (KEPT > 1) ? idx_bits(KEPT) : 0;
  localparam int unsigned SHIFT    = SAMPLE_BITS + KEPT_LOG;
  localparam int unsigned RECIP_B  = SHIFT + 1;
  localparam int unsigned PROD_B   = SAMPLE_BITS + RECIP_B;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + KEPT - 1) / KEPT;

  localparam int unsigned CNT_BITS = idx_bits(WINDOW);
  localparam int unsigned SUM_BITS = SAMPLE_BITS + idx_bits(WINDOW);
  localparam int unsigned TRIM_B   = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;

  localparam logic [SAMPLE_BITS-1:0] MIN_INIT  = '1;
  localparam logic [SAMPLE_BITS-1:0] QMIN_INIT = SAMPLE_BITS'(((64'd1 << SAMPLE_BITS) - 1) / KEPT);
  localparam logic [CNT_BITS-1:0]    LAST_CNT  = CNT_BITS'(WINDOW - 1);

  // Input register.
  logic                   a_vld_r;
  logic [SAMPLE_BITS-1:0] a_s_r;

  // Quotient stage.
  logic                   b_vld_r;
  logic [SAMPLE_BITS-1:0] b_s_r;
  logic [SAMPLE_BITS-1:0] b_q_r;

  // Window state.
  logic [CNT_BITS-1:0]    cnt_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [SAMPLE_BITS-1:0] min_r;
  logic [SAMPLE_BITS-1:0] max_r;
  logic [SAMPLE_BITS-1:0] qmin_r;
  logic [SAMPLE_BITS-1:0] qmax_r;

  // Output register.
  logic                out_vld_r;
  logic [OUT_BITS-1:0] out_d_r;

  logic                   out_free;
  logic                   b_last;
  logic                   b_fire;
  logic                   b_take;
  logic                   a_move;
  logic                   in_take;
  logic [PROD_B-1:0]      prod;
  logic [SAMPLE_BITS-1:0] a_q;
  logic                   new_min;
  logic                   new_max;
  logic [SAMPLE_BITS-1:0] min_nxt;
  logic [SAMPLE_BITS-1:0] max_nxt;
  logic [SAMPLE_BITS-1:0] qmin_nxt;
  logic [SAMPLE_BITS-1:0] qmax_nxt;
  logic [SUM_BITS-1:0]    sum_nxt;
  logic [TRIM_B-1:0]      trimmed;

  // Handshake chain: the accumulate stage holds only a window's last sample, and only
  // while the output register still carries an untaken result.
  assign out_free = !out_vld_r || out_ch.ready;
  assign b_last   = (cnt_r == LAST_CNT);
  assign b_fire   = b_vld_r && (!b_last || out_free);
  assign b_take   = !b_vld_r || b_fire;
  assign a_move   = a_vld_r && b_take;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready     = rst_n && (!a_vld_r || b_take);
  assign out_ch.valid    = out_vld_r;
  assign out_ch.filtered = out_d_r;

  // Truncating division by the kept-sample count as a multiply and shift.
  assign prod = PROD_B'(a_s_r) * PROD_B'(RECIP);
  assign a_q  = prod[SHIFT +: SAMPLE_BITS];

  // Strict compares, so only one copy of an extreme value is ever replaced.
  always_comb begin
    new_min  = (b_s_r < min_r);
    new_max  = (b_s_r > max_r);
    min_nxt  = new_min ? b_s_r : min_r;
    qmin_nxt = new_min ? b_q_r : qmin_r;
    max_nxt  = new_max ? b_s_r : max_r;
    qmax_nxt = new_max ? b_q_r : qmax_r;
    sum_nxt  = sum_r + SUM_BITS'(b_q_r);
    trimmed  = TRIM_B'(sum_nxt) - TRIM_B'(qmin_nxt) - TRIM_B'(qmax_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
      min_r     <= MIN_INIT;
      max_r     <= '0;
      qmin_r    <= QMIN_INIT;
      qmax_r    <= '0;
    end else begin
      if (in_take) begin
        a_vld_r <= 1'b1;
      end else if (a_move) begin
        a_vld_r <= 1'b0;
      end

      if (b_take) begin
        b_vld_r <= a_vld_r;
      end

      if (b_fire && b_last) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      if (b_fire) begin
        if (b_last) begin
          cnt_r     <= '0;
          sum_r     <= '0;
          min_r     <= MIN_INIT;
          max_r     <= '0;
          qmin_r    <= QMIN_INIT;
          qmax_r    <= '0;
        end else begin
          cnt_r  <= cnt_r + 1'b1;
          sum_r  <= sum_nxt;
          min_r  <= min_nxt;
          max_r  <= max_nxt;
          qmin_r <= qmin_nxt;
          qmax_r <= qmax_nxt;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_s_r <= in_ch.sample;
    end
    if (a_move) begin
      b_s_r <= a_s_r;
      b_q_r <= a_q;
    end
    if (b_fire && b_last) begin
      out_d_r <= trimmed[OUT_BITS-1:0];
    end
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the trimmed-mean sample filter top level.
module tb;
  import tmf_pkg::*;

  // The block runs at its default configuration: windows of nine samples, 12-bit samples.
  localparam int WINDOW      = 9;
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_SAMPLE  = (1 << SAMPLE_BITS) - 1;

  // A result is registered after the input, quotient and accumulate stages, so this many idle
  // cycles at the end is ample to catch a stray late transaction.
  localparam int DRAIN_CYCLES = 12;
  // Upper bound on how long the end of the run may wait for outstanding results.
  localparam int DRAIN_LIMIT  = 2000;
  // Number of random windows; together with the directed part this is 1476 samples.
  localparam int RANDOM_WINDOWS = 161;

  // Shapes of the random windows. Narrow clusters and flat windows stress the
  // duplicate handling of the minimum and the maximum; rails hit the field extremes.
  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_FLAT,
    SPREAD_RAILS
  } spread_t;

  // Tracks the window the same way the filter does and queues the filtered value
  // that each completed window must produce.
  class trimmed_mean_tracker;
    int unsigned            taken;
    logic [12:0]            quot_sum;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [OUT_BITS-1:0]    filtered_due[$];
    int unsigned            errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      taken    = 0;
      quot_sum = '0;
      lo       = '1;
      hi       = '0;
    endfunction

    // Folds one accepted sample into the window; on the window's last sample the
    // trimmed mean is queued. Truncation happens per sample, so dropping the extremes
    // means subtracting their quotients from the sum.
    function void take_sample(input logic [SAMPLE_BITS-1:0] s);
      int unsigned kept;
      int unsigned trimmed;
      kept     = WINDOW - 2;
      quot_sum = 13'(quot_sum + s / kept);
      if (s < lo) lo = s;
      if (s > hi) hi = s;
      taken++;
      if (taken == WINDOW) begin
        trimmed = quot_sum - lo / kept - hi / kept;
        filtered_due.push_back(trimmed[OUT_BITS-1:0]);
        restart();
      end
    endfunction

    // Compares one result transaction with the oldest outstanding expectation.
    function void check_filtered(input logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      if (filtered_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: filtered=%0d with nothing outstanding", got);
        return;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("filtered mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int unsigned outstanding();
      return filtered_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tmf_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  tmf_result_if                              out_ch ();

  trimmed_mean_sample_filter_top #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  trimmed_mean_tracker tracker = new();

  // When set, the corresponding side never idles, giving back-to-back stretches.
  bit calm_in;
  bit calm_out;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drives every block input to a known value before the first edge.
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    calm_in      = 1'b0;
    calm_out     = 1'b0;
  end

  // Offers one sample after a random gap and holds it until the filter accepts the
  // transaction. The sample is noted only at the edge where valid and ready meet.
  // When no gap is drawn, valid stays high into the next item with a single assignment.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    tracker.take_sample(s);
  endtask

  // Sends one whole window of random samples in the given shape.
  task automatic send_window(input spread_t spread);
    int base;
    int v;
    base = $urandom_range(0, MAX_SAMPLE);
    for (int i = 0; i < WINDOW; i++) begin
      case (spread)
        SPREAD_FULL: begin
          v = $urandom_range(0, MAX_SAMPLE);
        end
        SPREAD_NARROW: begin
          v = base + $urandom_range(0, 15);
          if (v > MAX_SAMPLE) v = MAX_SAMPLE;
        end
        SPREAD_FLAT: begin
          v = base;
        end
        default: begin
          v = $urandom_range(0, 1) ? MAX_SAMPLE - $urandom_range(0, 3) : $urandom_range(0, 3);
        end
      endcase
      send_sample(v[SAMPLE_BITS-1:0]);
    end
  endtask

  // Result side: draws a stall per result, then takes the next transaction and checks it.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm_out ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      tracker.check_filtered(out_ch.filtered);
    end
  end

  // Main sequence: reset, directed windows, random windows, then drain and report.
  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A window at full scale: every sample equal, so two of the equal values are dropped.
    for (int i = 0; i < WINDOW; i++) send_sample(SAMPLE_BITS'(MAX_SAMPLE));

    // Both rails appear twice, so only one copy of each may be dropped; the rest are
    // small values near the divisor and one mid-scale value.
    send_sample(0);
    send_sample(SAMPLE_BITS'(MAX_SAMPLE));
    send_sample(0);
    send_sample(SAMPLE_BITS'(MAX_SAMPLE));
    send_sample(7);
    send_sample(6);
    send_sample(13);
    send_sample(14);
    send_sample(12'h800);

    // A window of all zeros: the minimum and maximum are the same value.
    for (int i = 0; i < WINDOW; i++) send_sample(0);

    // Random windows; every sixteen windows the idling of each side is redrawn so that
    // back-to-back stretches alternate with gaps on either side.
    for (int w = 0; w < RANDOM_WINDOWS; w++) begin
      if (w % 16 == 0) begin
        calm_in  = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      send_window(spread_t'($urandom_range(0, 3)));
    end
    in_ch.valid <= 1'b0;

    // Let the idling of the result side resume so the drain sees stalls too.
    calm_out = 1'b0;
    waited   = 0;
    while (tracker.outstanding() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    // Any expectation that never arrived is a failure of its own.
    if (tracker.outstanding() > 0) begin
      tracker.errors += tracker.outstanding();
      $display("%0d expected results never arrived", tracker.outstanding());
    end

    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every gap and stall at its longest.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
